// File: sv/pus_pkg.sv
// Shared types and constants for the periodic update scheduler.
package pus_pkg;

    // Fixed field widths.
    localparam int unsigned SAMPLE_W = 32;
    localparam int unsigned CMD_W    = 3;
    localparam int unsigned NUM_CH   = 3;
    localparam int unsigned IDX_W    = 2;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_SCHEDULE = 3'd0;
    localparam logic [CMD_W-1:0] CMD_CANCEL   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CONSUME  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_NEXT     = 3'd3;
    localparam logic [CMD_W-1:0] CMD_QUERY    = 3'd4;

    // Status codes.
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    // ALU operation codes.
    localparam logic ALU_ADD = 1'b0;
    localparam logic ALU_SUB = 1'b1;

    // Request to the shared add/subtract unit.
    typedef struct packed {
        logic                op;
        logic [SAMPLE_W-1:0] a;
        logic [SAMPLE_W-1:0] b;
    } t_alu_req;

    // Response from the shared add/subtract unit.
    typedef struct packed {
        logic [SAMPLE_W-1:0] res;
        logic                borrow;
    } t_alu_rsp;

endpackage

// File: sv/periodic_update_scheduler.sv
// Top level of the periodic update scheduler: sequencer around one shared adder.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+-------------------------------------
//   in      | to block  | i_in_valid / o_in_stall   | i_cmd, i_category_mask, i_sample,
//           |           |                           | i_period
//   out     | from block| o_out_valid / i_out_stall | o_status, o_target, o_due_mask
//
// Schedule, cancel and query run a single execute step; consume checks each channel in turn
// and adds the period for each channel that advances; next, for an overdue periodic channel,
// finds the remainder by a restoring divide of one bit per cycle on the shared adder.
// Every command ends with a due-mask scan over all channels on the same adder.
// Reset is synchronous and active low; it clears all channel state and the output valid.
// A stalled output holds its result; the block takes no new item until its result is loaded.
module periodic_update_scheduler (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [pus_pkg::CMD_W-1:0]     i_cmd,
    input  logic [pus_pkg::NUM_CH-1:0]    i_category_mask,
    input  logic [pus_pkg::SAMPLE_W-1:0]  i_sample,
    input  logic [pus_pkg::SAMPLE_W-1:0]  i_period,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_status,
    output logic [pus_pkg::SAMPLE_W-1:0]  o_target,
    output logic [pus_pkg::NUM_CH-1:0]    o_due_mask
);
    import pus_pkg::*;

    // Sequencer states.
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_EXEC     = 4'd1;
    localparam logic [3:0] S_CONS_CHK = 4'd2;
    localparam logic [3:0] S_CONS_ADD = 4'd3;
    localparam logic [3:0] S_NX_CHK   = 4'd4;
    localparam logic [3:0] S_DIV      = 4'd5;
    localparam logic [3:0] S_FIN_A    = 4'd6;
    localparam logic [3:0] S_FIN_B    = 4'd7;
    localparam logic [3:0] S_DUE      = 4'd8;
    localparam logic [3:0] S_DONE     = 4'd9;

    localparam logic [IDX_W-1:0] CH_LAST  = IDX_W'(NUM_CH - 1);
    localparam logic [4:0]       DIV_LAST = 5'(SAMPLE_W - 1);

    logic [3:0]          r_state, n_state;
    logic [CMD_W-1:0]    r_cmd, n_cmd;
    logic [NUM_CH-1:0]   r_mask, n_mask;
    logic [SAMPLE_W-1:0] r_now, n_now;
    logic [SAMPLE_W-1:0] r_per, n_per;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic [4:0]          r_cnt, n_cnt;
    logic [SAMPLE_W-1:0] r_rem, n_rem;
    logic [SAMPLE_W-1:0] r_dvd, n_dvd;
    logic                r_status, n_status;
    logic [SAMPLE_W-1:0] r_target, n_target;
    logic [NUM_CH-1:0]   r_dmask, n_dmask;

    logic [SAMPLE_W-1:0] r_due_at [NUM_CH];
    logic [SAMPLE_W-1:0] n_due_at [NUM_CH];
    logic [SAMPLE_W-1:0] r_period [NUM_CH];
    logic [SAMPLE_W-1:0] n_period [NUM_CH];
    logic [NUM_CH-1:0]   r_pending, n_pending;

    logic                r_out_valid, n_out_valid;
    logic                r_o_status, n_o_status;
    logic [SAMPLE_W-1:0] r_o_target, n_o_target;
    logic [NUM_CH-1:0]   r_o_dmask, n_o_dmask;

    t_alu_req alu_req;
    t_alu_rsp alu_rsp;
    logic     sel;

    pus_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    // Sequencer and datapath next-state logic.
    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_mask      = r_mask;
        n_now       = r_now;
        n_per       = r_per;
        n_idx       = r_idx;
        n_cnt       = r_cnt;
        n_rem       = r_rem;
        n_dvd       = r_dvd;
        n_status    = r_status;
        n_target    = r_target;
        n_dmask     = r_dmask;
        n_due_at    = r_due_at;
        n_period    = r_period;
        n_pending   = r_pending;
        n_out_valid = r_out_valid;
        n_o_status  = r_o_status;
        n_o_target  = r_o_target;
        n_o_dmask   = r_o_dmask;
        sel         = 1'b0;

        alu_req.op = ALU_SUB;
        alu_req.a  = r_now;
        alu_req.b  = r_due_at[r_idx];

        // A taken result frees the output register.
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd   = i_cmd;
                    n_mask  = i_category_mask;
                    n_now   = i_sample;
                    n_per   = i_period;
                    n_state = S_EXEC;
                end
            end

            S_EXEC: begin
                n_status = STATUS_OK;
                n_target = '0;
                n_dmask  = '0;
                n_idx    = '0;
                n_state  = S_DUE;
                case (r_cmd)
                    CMD_SCHEDULE: begin
                        for (int i = 0; i < NUM_CH; i++) begin
                            if (r_mask[i]) begin
                                n_due_at[i]  = r_now;
                                n_period[i]  = r_per;
                                n_pending[i] = 1'b1;
                            end
                        end
                    end
                    CMD_CANCEL: begin
                        for (int i = 0; i < NUM_CH; i++) begin
                            if (r_mask[i]) begin
                                n_pending[i] = 1'b0;
                                n_period[i]  = '0;
                            end
                        end
                    end
                    CMD_CONSUME: begin
                        n_state = S_CONS_CHK;
                    end
                    CMD_NEXT: begin
                        // Exactly one channel, and it must be pending.
                        case (r_mask)
                            3'b001: n_idx = 2'd0;
                            3'b010: n_idx = 2'd1;
                            3'b100: n_idx = 2'd2;
                            default: n_idx = '0;
                        endcase
                        if ((r_mask == 3'b001 || r_mask == 3'b010 || r_mask == 3'b100)
                            && (r_pending & r_mask) != '0) begin
                            n_state = S_NX_CHK;
                        end else begin
                            n_status = STATUS_ERR;
                            n_idx    = '0;
                        end
                    end
                    default: begin
                        n_state = S_DUE;
                    end
                endcase
            end

            // Consume: check one channel; advance it or clear it if it is due.
            S_CONS_CHK: begin
                sel = r_mask[r_idx] & r_pending[r_idx] & ~alu_rsp.res[SAMPLE_W-1];
                if (sel && r_period[r_idx] != '0) begin
                    n_state = S_CONS_ADD;
                end else begin
                    if (sel) begin
                        n_pending[r_idx] = 1'b0;
                    end
                    if (r_idx == CH_LAST) begin
                        n_idx   = '0;
                        n_state = S_DUE;
                    end else begin
                        n_idx = r_idx + 2'd1;
                    end
                end
            end

            S_CONS_ADD: begin
                alu_req.op = ALU_ADD;
                alu_req.a  = r_due_at[r_idx];
                alu_req.b  = r_period[r_idx];
                n_due_at[r_idx] = alu_rsp.res;
                if (r_idx == CH_LAST) begin
                    n_idx   = '0;
                    n_state = S_DUE;
                end else begin
                    n_idx   = r_idx + 2'd1;
                    n_state = S_CONS_CHK;
                end
            end

            // Next: an overdue periodic channel needs the elapsed remainder.
            S_NX_CHK: begin
                if (r_period[r_idx] != '0 && !alu_rsp.res[SAMPLE_W-1]) begin
                    n_dvd   = alu_rsp.res;
                    n_rem   = '0;
                    n_cnt   = '0;
                    n_state = S_DIV;
                end else begin
                    n_target = r_due_at[r_idx];
                    n_idx    = '0;
                    n_state  = S_DUE;
                end
            end

            // Restoring divide, one quotient bit per cycle; only the remainder is kept.
            // The elapsed count is below 2^31, so the remainder never needs its top bit.
            S_DIV: begin
                alu_req.op = ALU_SUB;
                alu_req.a  = {r_rem[SAMPLE_W-2:0], r_dvd[SAMPLE_W-1]};
                alu_req.b  = r_period[r_idx];
                n_rem      = alu_rsp.borrow ? alu_req.a : alu_rsp.res;
                n_dvd      = {r_dvd[SAMPLE_W-2:0], 1'b0};
                n_cnt      = r_cnt + 5'd1;
                if (r_cnt == DIV_LAST) begin
                    n_state = S_FIN_A;
                end
            end

            // New due sample is now + (period - remainder).
            S_FIN_A: begin
                alu_req.op = ALU_SUB;
                alu_req.a  = r_period[r_idx];
                alu_req.b  = r_rem;
                n_rem      = alu_rsp.res;
                n_state    = S_FIN_B;
            end

            S_FIN_B: begin
                alu_req.op      = ALU_ADD;
                alu_req.a       = r_now;
                alu_req.b       = r_rem;
                n_due_at[r_idx] = alu_rsp.res;
                n_target        = alu_rsp.res;
                n_idx           = '0;
                n_state         = S_DUE;
            end

            // Scan the channels for the due mask after the update.
            S_DUE: begin
                n_dmask[r_idx] = r_pending[r_idx] & ~alu_rsp.res[SAMPLE_W-1];
                if (r_idx == CH_LAST) begin
                    n_idx   = '0;
                    n_state = S_DONE;
                end else begin
                    n_idx = r_idx + 2'd1;
                end
            end

            // Load the output register once it is free.
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_o_status  = r_status;
                    n_o_target  = r_target;
                    n_o_dmask   = r_dmask;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control and channel state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_pending   <= '0;
            r_idx       <= '0;
            r_cnt       <= '0;
            for (int i = 0; i < NUM_CH; i++) begin
                r_due_at[i] <= '0;
                r_period[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_pending   <= n_pending;
            r_idx       <= n_idx;
            r_cnt       <= n_cnt;
            r_due_at    <= n_due_at;
            r_period    <= n_period;
        end
    end

    // Working and output payload registers.
    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_mask     <= n_mask;
        r_now      <= n_now;
        r_per      <= n_per;
        r_rem      <= n_rem;
        r_dvd      <= n_dvd;
        r_status   <= n_status;
        r_target   <= n_target;
        r_dmask    <= n_dmask;
        r_o_status <= n_o_status;
        r_o_target <= n_o_target;
        r_o_dmask  <= n_o_dmask;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_status    = r_o_status;
    assign o_target    = r_o_target;
    assign o_due_mask  = r_o_dmask;

endmodule

// File: sv/pus_alu.sv
// Shared 32-bit add/subtract unit with borrow output.
module pus_alu (
    input  pus_pkg::t_alu_req i_req,
    output pus_pkg::t_alu_rsp o_rsp
);
    import pus_pkg::*;

    logic [SAMPLE_W:0] sum;

    // One adder serves both operations; the borrow is the carry-out of the subtract.
    always_comb begin
        if (i_req.op == ALU_SUB) begin
            sum = {1'b0, i_req.a} - {1'b0, i_req.b};
        end else begin
            sum = {1'b0, i_req.a} + {1'b0, i_req.b};
        end
        o_rsp.res    = sum[SAMPLE_W-1:0];
        o_rsp.borrow = (i_req.op == ALU_SUB) ? sum[SAMPLE_W] : 1'b0;
    end

endmodule

// File: sv/pus_checker.sv
// Port-level checker for the periodic update scheduler, bound to the top level.
module pus_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic                          o_status,
    input logic [pus_pkg::SAMPLE_W-1:0]  o_target,
    input logic [pus_pkg::NUM_CH-1:0]    o_due_mask
);
    import pus_pkg::*;

    // A stalled result stays valid and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_status) && $stable(o_target) && $stable(o_due_mask))
        else $error("stalled result changed");

    // An error result never carries a target.
    a_err_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == STATUS_ERR |-> o_target == '0)
        else $error("error result with nonzero target");

    // The block is busy right after it takes an item.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken again without processing");

    // Reset leaves the block empty and ready.
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("block not idle after reset");

endmodule

bind periodic_update_scheduler pus_checker u_pus_checker (.*);

// File: bench/tb.sv
// Self-checking testbench for the periodic update scheduler.
module tb;
    import pus_pkg::*;

    // Channel masks used by the stimulus.
    localparam logic [NUM_CH-1:0] MASK_NONE = 3'b000;
    localparam logic [NUM_CH-1:0] MASK_GAIN = 3'b001;
    localparam logic [NUM_CH-1:0] MASK_RF   = 3'b010;
    localparam logic [NUM_CH-1:0] MASK_RATE = 3'b100;
    localparam logic [NUM_CH-1:0] MASK_ALL  = 3'b111;

    // Highest command code; codes above CMD_QUERY are unassigned.
    localparam logic [CMD_W-1:0] CMD_LAST = 3'd7;

    // Settle time after the last reply, and the overall time limit.
    localparam int DRAIN_CYCLES = 100;
    localparam int RUN_LIMIT    = 4_000_000;

    typedef struct {
        logic                status;
        logic [SAMPLE_W-1:0] target;
        logic [NUM_CH-1:0]   due_mask;
    } t_sched_reply;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    logic [CMD_W-1:0]    i_cmd = CMD_QUERY;
    logic [NUM_CH-1:0]   i_category_mask = MASK_NONE;
    logic [SAMPLE_W-1:0] i_sample = '0;
    logic [SAMPLE_W-1:0] i_period = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic                o_status;
    logic [SAMPLE_W-1:0] o_target;
    logic [NUM_CH-1:0]   o_due_mask;

    // Shadow copy of the channel state.
    logic [SAMPLE_W-1:0] shadow_due [NUM_CH];
    logic [SAMPLE_W-1:0] shadow_period [NUM_CH];
    logic [NUM_CH-1:0]   shadow_pending;

    t_sched_reply owed_replies [$];
    int           mismatches = 0;
    int           cmds_sent = 0;

    // Pacing of both sides; calm turns all idling off.
    bit calm = 1'b0;
    int burst_left = 0;
    int max_gap = 6;
    int stall_left = 0;
    bit stall_phase = 1'b0;

    periodic_update_scheduler dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_cmd           (i_cmd),
        .i_category_mask (i_category_mask),
        .i_sample        (i_sample),
        .i_period        (i_period),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_target        (o_target),
        .o_due_mask      (o_due_mask)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // A sample has reached a due point when the wrapped difference is not negative.
    function automatic bit has_reached(logic [SAMPLE_W-1:0] now, logic [SAMPLE_W-1:0] when);
        logic [SAMPLE_W-1:0] diff;
        diff = now - when;
        return !diff[SAMPLE_W-1];
    endfunction

    function automatic logic [NUM_CH-1:0] due_channels(logic [SAMPLE_W-1:0] now);
        logic [NUM_CH-1:0] m;
        m = MASK_NONE;
        for (int i = 0; i < NUM_CH; i++)
            if (shadow_pending[i] && has_reached(now, shadow_due[i]))
                m[i] = 1'b1;
        return m;
    endfunction

    // Applies one command to the shadow state and returns the reply it should produce.
    function automatic t_sched_reply advance_scheduler(logic [CMD_W-1:0] cmd,
                                                       logic [NUM_CH-1:0] mask,
                                                       logic [SAMPLE_W-1:0] now,
                                                       logic [SAMPLE_W-1:0] per);
        t_sched_reply        r;
        logic [NUM_CH-1:0]   sel;
        logic [SAMPLE_W-1:0] t;
        logic [SAMPLE_W-1:0] p;
        logic [SAMPLE_W-1:0] elapsed;
        int                  idx;
        r.status = STATUS_OK;
        r.target = '0;
        case (cmd)
            CMD_SCHEDULE: begin
                for (int i = 0; i < NUM_CH; i++)
                    if (mask[i]) begin
                        shadow_period[i] = per;
                        shadow_due[i] = now;
                        shadow_pending[i] = 1'b1;
                    end
            end
            CMD_CANCEL: begin
                for (int i = 0; i < NUM_CH; i++)
                    if (mask[i]) begin
                        shadow_pending[i] = 1'b0;
                        shadow_period[i] = '0;
                    end
            end
            CMD_CONSUME: begin
                // Due channels re-arm by their period; one-shot channels are retired.
                sel = mask & due_channels(now);
                for (int i = 0; i < NUM_CH; i++)
                    if (sel[i]) begin
                        if (shadow_period[i] != '0)
                            shadow_due[i] = shadow_due[i] + shadow_period[i];
                        else
                            shadow_pending[i] = 1'b0;
                    end
            end
            CMD_NEXT: begin
                case (mask)
                    MASK_GAIN: idx = 0;
                    MASK_RF:   idx = 1;
                    MASK_RATE: idx = 2;
                    default:   idx = -1;
                endcase
                if (idx < 0 || (shadow_pending & mask) == MASK_NONE) begin
                    r.status = STATUS_ERR;
                end else begin
                    // An overdue periodic channel jumps to the first boundary past now.
                    t = shadow_due[idx];
                    p = shadow_period[idx];
                    if (p != '0 && has_reached(now, t)) begin
                        elapsed = now - t;
                        t = t + (elapsed / p + 32'd1) * p;
                        shadow_due[idx] = t;
                    end
                    r.target = t;
                end
            end
            default: ;
        endcase
        r.due_mask = due_channels(now);
        return r;
    endfunction

    // Sends one command, pausing first when the current burst has run out.
    task automatic send_cmd(logic [CMD_W-1:0] cmd, logic [NUM_CH-1:0] mask,
                            logic [SAMPLE_W-1:0] now, logic [SAMPLE_W-1:0] per);
        int gap;
        if (burst_left == 0) begin
            gap = calm ? 0 : $urandom_range(1, max_gap);
            burst_left = calm ? 1 : $urandom_range(1, 8);
            repeat (gap) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_cmd <= cmd;
        i_category_mask <= mask;
        i_sample <= now;
        i_period <= per;
        do @(posedge i_clk); while (o_in_stall);
        owed_replies.push_back(advance_scheduler(cmd, mask, now, per));
        cmds_sent++;
    endtask

    // Output stall pattern: alternating open and stalled runs of random length.
    always @(negedge i_clk) begin
        if (!i_rst_n || calm) begin
            i_out_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (stall_left == 0) begin
                stall_phase = !stall_phase;
                stall_left = stall_phase ? $urandom_range(1, 12) : $urandom_range(1, 30);
            end
            stall_left--;
            i_out_stall <= stall_phase;
        end
    end

    // Compare every reply transfer with the oldest owed reply.
    always @(posedge i_clk) begin
        t_sched_reply want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (owed_replies.size() == 0) begin
                $error("reply with no command outstanding: status %0d target %h due_mask %b",
                       o_status, o_target, o_due_mask);
                mismatches++;
            end else begin
                want = owed_replies.pop_front();
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    mismatches++;
                end
                if (o_target !== want.target) begin
                    $error("target: expected %h, got %h", want.target, o_target);
                    mismatches++;
                end
                if (o_due_mask !== want.due_mask) begin
                    $error("due_mask: expected %b, got %b", want.due_mask, o_due_mask);
                    mismatches++;
                end
            end
        end
    end

    // Hand-picked commands: error paths, wrap, one-shot, overdue and unused codes.
    task automatic test_directed();
        send_cmd(CMD_QUERY, MASK_NONE, 32'h0000_0000, 32'h0000_0000);
        send_cmd(CMD_NEXT, MASK_GAIN, 32'h0000_0000, 32'h0000_0000);
        send_cmd(CMD_SCHEDULE, MASK_ALL, 32'hFFFF_FFF0, 32'hFFFF_FFFF);
        send_cmd(CMD_QUERY, MASK_ALL, 32'h0000_0005, 32'h0000_0000);
        send_cmd(CMD_NEXT, MASK_NONE, 32'h0000_0010, 32'h0000_0000);
        send_cmd(CMD_NEXT, MASK_ALL, 32'h0000_0010, 32'h0000_0000);
        send_cmd(CMD_NEXT, MASK_GAIN | MASK_RF, 32'h0000_0010, 32'h0000_0000);
        send_cmd(CMD_NEXT, MASK_RF, 32'h0000_0010, 32'h0000_0000);
        send_cmd(CMD_CANCEL, MASK_RF, 32'h0000_0000, 32'hFFFF_FFFF);
        send_cmd(CMD_NEXT, MASK_RF, 32'h0000_0010, 32'h0000_0000);
        // One-shot gain channel and a short-period sample-rate channel.
        send_cmd(CMD_SCHEDULE, MASK_GAIN, 32'd100, 32'd0);
        send_cmd(CMD_NEXT, MASK_GAIN, 32'd500, 32'd0);
        send_cmd(CMD_SCHEDULE, MASK_RATE, 32'd1000, 32'd7);
        send_cmd(CMD_NEXT, MASK_RATE, 32'd900, 32'd0);
        send_cmd(CMD_NEXT, MASK_RATE, 32'd1020, 32'd0);
        send_cmd(CMD_CONSUME, MASK_ALL, 32'd1030, 32'd0);
        send_cmd(CMD_CONSUME, MASK_RATE, 32'd1000, 32'd0);
        // Unassigned codes behave as a plain query.
        for (int c = CMD_QUERY + 1; c <= CMD_LAST; c++)
            send_cmd(CMD_W'(c), MASK_ALL, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // A distance one short of half the range is still due; half the range is not yet due.
        send_cmd(CMD_SCHEDULE, MASK_ALL, 32'h7FFF_FFFF, 32'd1);
        send_cmd(CMD_QUERY, MASK_NONE, 32'hFFFF_FFFE, 32'd0);
        send_cmd(CMD_NEXT, MASK_GAIN, 32'hFFFF_FFFE, 32'd0);
        send_cmd(CMD_SCHEDULE, MASK_RF, 32'h0000_0000, 32'h8000_0000);
        send_cmd(CMD_NEXT, MASK_RF, 32'h7FFF_FFFF, 32'd0);
        send_cmd(CMD_CONSUME, MASK_ALL, 32'h8000_0000, 32'd0);
        send_cmd(CMD_CANCEL, MASK_ALL, 32'h8000_0000, 32'd0);
    endtask

    // Arm a few channels, then walk the sample count mostly forward, with an occasional step back, and work them.
    task automatic run_schedule_sequences(int n_cmds);
        int                  first;
        int                  pick;
        logic [SAMPLE_W-1:0] now_s;
        logic [SAMPLE_W-1:0] per;
        logic [NUM_CH-1:0]   m;
        first = cmds_sent;
        while (cmds_sent - first < n_cmds) begin
            now_s = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFC0 + $urandom_range(0, 63)
                                                 : $urandom;
            repeat ($urandom_range(1, 3)) begin
                m = NUM_CH'($urandom_range(1, 7));
                case ($urandom_range(0, 5))
                    0:       per = '0;
                    1:       per = $urandom;
                    default: per = $urandom_range(1, 64);
                endcase
                send_cmd(CMD_SCHEDULE, m, now_s + $urandom_range(0, 40), per);
            end
            repeat ($urandom_range(4, 12)) begin
                pick = $urandom_range(0, 9);
                if (pick == 9)
                    now_s = now_s - $urandom_range(0, 100);
                else
                    now_s = now_s + $urandom_range(0, 60);
                m = NUM_CH'($urandom_range(0, 7));
                case (pick)
                    0, 1, 2, 3: send_cmd(CMD_CONSUME, m, now_s, $urandom);
                    4, 5, 6:    send_cmd(CMD_NEXT, MASK_GAIN << $urandom_range(0, 2), now_s,
                                         $urandom);
                    7:          send_cmd(CMD_QUERY, m, now_s, $urandom);
                    8:          send_cmd(CMD_CANCEL, m, now_s, $urandom);
                    default:    send_cmd(CMD_NEXT, m, now_s, $urandom);
                endcase
            end
        end
    endtask

    task automatic test_sequences_with_idling();
        calm = 1'b0;
        max_gap = 6;
        run_schedule_sequences(260);
    endtask

    // Fully random fields, unassigned codes included.
    task automatic test_noise();
        calm = 1'b0;
        max_gap = 12;
        repeat (80)
            send_cmd(CMD_W'($urandom_range(0, CMD_LAST)), NUM_CH'($urandom_range(0, 7)),
                     $urandom, $urandom);
    endtask

    task automatic test_back_to_back();
        calm = 1'b1;
        burst_left = 0;
        run_schedule_sequences(60);
        calm = 1'b0;
    endtask

    initial begin
        shadow_pending = MASK_NONE;
        for (int i = 0; i < NUM_CH; i++) begin
            shadow_due[i] = '0;
            shadow_period[i] = '0;
        end
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_sequences_with_idling();
        test_noise();
        test_back_to_back();

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (owed_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Hard stop in case the block hangs.
    initial begin
        #RUN_LIMIT;
        $display("Verification failed");
        $finish;
    end

endmodule
